// File: rtl/fclp_pkg.sv
// Shared types and constants for the flight code linear probe table.
`default_nettype none
package fclp_pkg;

  localparam int SLOTS = 1024;
  localparam int SLOT_W = $clog2(SLOTS);

  localparam int LETTER_W = 5;
  localparam int NUMBER_W = 14;
  localparam int COUNT_W = 3;
  localparam int TAG_W = 16;
  localparam int STATUS_W = 2;
  localparam int INDEX_W = 10;

  localparam int LETTER_RADIX = 26;
  localparam int HASH_MULT = 9999;
  localparam int KEY_W = 10;
  localparam int HASH_W = 25;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd3;

  typedef struct packed {
    logic                valid;
    logic [LETTER_W-1:0] letter_first;
    logic [LETTER_W-1:0] letter_second;
    logic [NUMBER_W-1:0] flight_number;
    logic [COUNT_W-1:0]  digit_count;
    logic [TAG_W-1:0]    record_tag;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic                clr_write;
    logic                latch_req;
    logic                calc_key;
    logic                calc_home;
    logic                rd_en;
    logic                advance;
    logic                ins_write;
    logic                res_load;
    logic [STATUS_W-1:0] res_code;
    logic                out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic entry_valid;
    logic key_match;
    logic last_probe;
    logic is_search;
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

// File: rtl/fclp_if.sv
// Request and response channel interfaces of the flight code table.
`default_nettype none
interface fclp_req_if;
  logic                            valid;
  logic                            ready;
  logic                            operation;
  logic [fclp_pkg::LETTER_W-1:0]   letter_first;
  logic [fclp_pkg::LETTER_W-1:0]   letter_second;
  logic [fclp_pkg::NUMBER_W-1:0]   flight_number;
  logic [fclp_pkg::COUNT_W-1:0]    digit_count;
  logic [fclp_pkg::TAG_W-1:0]      record_tag;

  modport source (output valid, operation, letter_first, letter_second, flight_number,
                  digit_count, record_tag, input ready);
  modport sink (input valid, operation, letter_first, letter_second, flight_number,
                digit_count, record_tag, output ready);
endinterface

interface fclp_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [fclp_pkg::STATUS_W-1:0]   status;
  logic [fclp_pkg::INDEX_W-1:0]    slot_index;
  logic [fclp_pkg::TAG_W-1:0]      found_tag;

  modport source (output valid, status, slot_index, found_tag, input ready);
  modport sink (input valid, status, slot_index, found_tag, output ready);
endinterface
`default_nettype wire

// File: rtl/fclp_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module fclp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/fclp_ctrl.sv
// Controller state machine: clearing pass, hashing steps and the probe loop.
`default_nettype none
module fclp_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire fclp_pkg::sts_t sts,
  output fclp_pkg::cmd_t     cmd
);
  import fclp_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_KEY   = 3'd2;
  localparam logic [2:0] S_HOME  = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_CHECK = 3'd5;
  localparam logic [2:0] S_RESP  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_req = 1'b1;
          state_next = S_KEY;
        end
      end
      S_KEY: begin
        cmd.calc_key = 1'b1;
        state_next = S_HOME;
      end
      S_HOME: begin
        cmd.calc_home = 1'b1;
        state_next = S_READ;
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (!sts.entry_valid) begin
          cmd.res_load = 1'b1;
          cmd.res_code = sts.is_search ? ST_NOT_FOUND : ST_INSERTED;
          cmd.ins_write = !sts.is_search;
          state_next = S_RESP;
        end else if (sts.is_search && sts.key_match) begin
          cmd.res_load = 1'b1;
          cmd.res_code = ST_FOUND;
          state_next = S_RESP;
        end else if (sts.last_probe) begin
          // Every slot has been visited once.
          cmd.res_load = 1'b1;
          cmd.res_code = sts.is_search ? ST_NOT_FOUND : ST_FULL;
          state_next = S_RESP;
        end else begin
          cmd.advance = 1'b1;
          state_next = S_READ;
        end
      end
      S_RESP: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/fclp_dp.sv
// Datapath: request registers, home slot hash, entry RAM, compare and output register.
`default_nettype none
module fclp_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire fclp_pkg::cmd_t                cmd,
  output fclp_pkg::sts_t                     sts,
  input  wire logic                          operation,
  input  wire logic [fclp_pkg::LETTER_W-1:0] letter_first,
  input  wire logic [fclp_pkg::LETTER_W-1:0] letter_second,
  input  wire logic [fclp_pkg::NUMBER_W-1:0] flight_number,
  input  wire logic [fclp_pkg::COUNT_W-1:0]  digit_count,
  input  wire logic [fclp_pkg::TAG_W-1:0]    record_tag,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [fclp_pkg::STATUS_W-1:0] status,
  output logic      [fclp_pkg::INDEX_W-1:0]  slot_index,
  output logic      [fclp_pkg::TAG_W-1:0]    found_tag
);
  import fclp_pkg::*;

  logic                op;
  entry_t              req;
  logic [KEY_W-1:0]    key_sum;
  logic [HASH_W-1:0]   home_full;
  logic [SLOT_W-1:0]   pos;
  logic [SLOT_W-1:0]   probe_cnt;
  logic [SLOT_W-1:0]   clr_addr;
  logic [STATUS_W-1:0] res_status;
  logic [SLOT_W-1:0]   res_slot;
  logic [TAG_W-1:0]    res_tag;

  logic                ram_wr_en;
  logic [SLOT_W-1:0]   ram_wr_addr;
  entry_t              ram_wr_data;
  entry_t              ram_rd_data;

  // Request fields, kept for the whole operation.
  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      op <= operation;
      req.valid <= 1'b1;
      req.letter_first <= letter_first;
      req.letter_second <= letter_second;
      req.flight_number <= flight_number;
      req.digit_count <= digit_count;
      req.record_tag <= record_tag;
    end
  end

  // The letter pair and the home slot take one multiplication each.
  assign home_full = HASH_W'(key_sum) * HASH_W'(HASH_MULT) + HASH_W'(req.flight_number);

  always_ff @(posedge clk) begin
    if (cmd.calc_key) begin
      key_sum <= KEY_W'(req.letter_first * KEY_W'(LETTER_RADIX)) + KEY_W'(req.letter_second);
    end
    // SLOTS is a power of two, so the modulo keeps the low bits.
    if (cmd.calc_home) begin
      pos <= home_full[SLOT_W-1:0];
      probe_cnt <= '0;
    end else if (cmd.advance) begin
      pos <= (pos == SLOT_W'(SLOTS - 1)) ? '0 : pos + 1'b1;
      probe_cnt <= probe_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_write) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  assign ram_wr_en = cmd.clr_write | cmd.ins_write;
  assign ram_wr_addr = cmd.clr_write ? clr_addr : pos;
  assign ram_wr_data = cmd.clr_write ? entry_t'('0) : req;

  fclp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (pos),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_status <= cmd.res_code;
      res_slot <= (cmd.res_code == ST_INSERTED || cmd.res_code == ST_FOUND) ? pos : '0;
      res_tag <= (cmd.res_code == ST_FOUND) ? ram_rd_data.record_tag : '0;
    end
  end

  // Output register; the result stays here until its beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status <= res_status;
      slot_index <= INDEX_W'(res_slot);
      found_tag <= res_tag;
    end
  end

  always_comb begin
    sts.clr_last = (clr_addr == SLOT_W'(SLOTS - 1));
    sts.entry_valid = ram_rd_data.valid;
    sts.key_match = (ram_rd_data.letter_first == req.letter_first) &&
                    (ram_rd_data.letter_second == req.letter_second) &&
                    (ram_rd_data.flight_number == req.flight_number) &&
                    (ram_rd_data.digit_count == req.digit_count);
    sts.last_probe = (probe_cnt == SLOT_W'(SLOTS - 1));
    sts.is_search = (op == OP_SEARCH);
    sts.out_busy = out_valid && !out_ready;
  end

endmodule
`default_nettype wire

// File: rtl/flight_code_linear_probe_table_core.sv
// Response: after a request beat is accepted, the key and the home slot are computed in turn,
// then the probes run; the response waits while the previous one is still held at the output.
// Each probe is a RAM read and a compare, and the sequential probe loop over the entry RAM
// sets the pace; a new request beat is taken only once the previous response is loaded out.
// Reset: synchronous; a clearing pass writes each of the 1024 slots empty, and
// no request beat is taken until it ends.
`default_nettype none
module flight_code_linear_probe_table_core (
  input  wire logic clk,
  input  wire logic rst,
  fclp_req_if.sink  req,
  fclp_rsp_if.source rsp
);
  import fclp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  fclp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fclp_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .operation     (req.operation),
    .letter_first  (req.letter_first),
    .letter_second (req.letter_second),
    .flight_number (req.flight_number),
    .digit_count   (req.digit_count),
    .record_tag    (req.record_tag),
    .out_valid     (rsp.valid),
    .out_ready     (rsp.ready),
    .status        (rsp.status),
    .slot_index    (rsp.slot_index),
    .found_tag     (rsp.found_tag)
  );

`ifndef ASSERT_OFF
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> rsp.valid)
    else $error("loaded response is not presented");

  a_no_slot_on_miss: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status == ST_NOT_FOUND || rsp.status == ST_FULL)
      |-> (rsp.slot_index == '0) && (rsp.found_tag == '0))
    else $error("miss or full response carries a slot or tag");

  a_insert_no_tag: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status == ST_INSERTED) |-> (rsp.found_tag == '0))
    else $error("insert response carries a tag");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clr_write |-> !req.ready)
    else $error("request taken during clearing pass");
`endif

endmodule
`default_nettype wire
